@@ design/fdn_pkg.sv @@
package fdn_pkg;

  localparam logic [7:0] SPACE_BYTE       = 8'h20;
  localparam logic [4:0] BASE_LAST_OFS    = 5'd7;
  localparam logic [4:0] EXT_FIRST_OFS    = 5'd8;
  localparam logic [4:0] EXT_LAST_OFS     = 5'd10;
  localparam logic [4:0] CLUSTER_HIGH_OFS = 5'h14;
  localparam logic [4:0] CLUSTER_LOW_OFS  = 5'h1A;
  localparam logic [4:0] SIZE_OFS         = 5'h1C;
  localparam logic [4:0] ENTRY_LAST_OFS   = 5'd31;

  localparam logic [63:0] TARGET_BASE_RESET = 64'h2020_2020_2020_2020;
  localparam logic [23:0] TARGET_EXT_RESET  = 24'h20_2020;

  typedef enum logic [0:0] {
    CFG_TARGET_BASE = 1'b0,
    CFG_TARGET_EXT  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic        found;
    logic [31:0] start_cluster;
    logic [31:0] file_size;
  } result_t;

  typedef struct packed {
    logic equal;
    logic finished;
  } cmp_state_t;

  function automatic cmp_state_t compare_step(logic [7:0] got, logic [7:0] want,
                                              cmp_state_t cur);
    cmp_state_t nxt;
    logic       got_sp;
    logic       want_sp;
    nxt     = cur;
    got_sp  = (got == SPACE_BYTE);
    want_sp = (want == SPACE_BYTE);
    if (!cur.finished) begin
      if (got_sp || want_sp) begin
        if (got_sp != want_sp) nxt.equal = 1'b0;
        nxt.finished = 1'b1;
      end else if (got != want) begin
        nxt.equal = 1'b0;
      end
    end
    return nxt;
  endfunction

endpackage

@@ design/fat_dir_entry_name_match_core.sv @@
// A byte accepted into the input register is processed from there when it steps; the result
// of an entry's last byte is loaded into the result register and shown from there on out_*.
// One directory byte per cycle while the input register does not stall; one result word per 32 bytes.
// The input register stalls only on an entry's last byte while the result register is full
// and out_tready is low.
// Reset (rst_n low, synchronous): entry offset zero, captures cleared, both
// targets back to space padding, no word held.
module fat_dir_entry_name_match_core
  import fdn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] dir_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [0] found, [32:1] start_cluster, [64:33] file_size, [71:65] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] target_base_r;
  logic [23:0] target_ext_r;
  logic        stg_valid_r;
  logic [7:0]  stg_byte_r;
  logic        last;
  logic        free;
  logic        step;
  result_t     result;
  result_t     out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_base_r <= TARGET_BASE_RESET;
      target_ext_r  <= TARGET_EXT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TARGET_BASE: target_base_r <= cfg_data;
        CFG_TARGET_EXT:  target_ext_r  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign step      = stg_valid_r && (!last || free);
  assign in_tready = !stg_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_byte_r <= in_tdata;
    end
  end

  fdn_entry u_entry (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .dir_byte    (stg_byte_r),
    .target_base (target_base_r),
    .target_ext  (target_ext_r),
    .last        (last),
    .result      (result)
  );

  fdn_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && last),
    .result     (result),
    .free       (free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {7'd0, out_result.file_size, out_result.start_cluster, out_result.found};

endmodule

@@ design/fdn_entry.sv @@
module fdn_entry
  import fdn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  dir_byte,
  input  logic [63:0] target_base,
  input  logic [23:0] target_ext,
  output logic        last,
  output result_t     result
);

  logic [4:0]  pos_r, pos_nxt;
  cmp_state_t  base_r, base_nxt;
  cmp_state_t  ext_r, ext_nxt;
  logic [15:0] hi_r, hi_nxt;
  logic [15:0] lo_r, lo_nxt;
  logic [31:0] size_r, size_nxt;

  logic [7:0]  want_base;
  logic [7:0]  want_ext;

  assign want_base = target_base[{pos_r[2:0], 3'b000} +: 8];
  assign want_ext  = target_ext[{pos_r[1:0], 3'b000} +: 8];
  assign last      = (pos_r == ENTRY_LAST_OFS);

  always_comb begin
    pos_nxt  = pos_r + 5'd1;
    base_nxt = base_r;
    ext_nxt  = ext_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    size_nxt = size_r;
    if (pos_r <= BASE_LAST_OFS) begin
      base_nxt = compare_step(dir_byte, want_base, base_r);
    end else if (pos_r <= EXT_LAST_OFS) begin
      ext_nxt = compare_step(dir_byte, want_ext, ext_r);
    end else if (pos_r == CLUSTER_HIGH_OFS) begin
      hi_nxt[7:0] = dir_byte;
    end else if (pos_r == CLUSTER_HIGH_OFS + 5'd1) begin
      hi_nxt[15:8] = dir_byte;
    end else if (pos_r == CLUSTER_LOW_OFS) begin
      lo_nxt[7:0] = dir_byte;
    end else if (pos_r == CLUSTER_LOW_OFS + 5'd1) begin
      lo_nxt[15:8] = dir_byte;
    end else if (pos_r >= SIZE_OFS) begin
      size_nxt[{pos_r[1:0], 3'b000} +: 8] = dir_byte;
    end
  end

  assign result.found         = base_nxt.equal && ext_nxt.equal;
  assign result.start_cluster = {hi_nxt, lo_nxt};
  assign result.file_size     = size_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      pos_r  <= '0;
      base_r <= '{equal: 1'b1, finished: 1'b0};
      ext_r  <= '{equal: 1'b1, finished: 1'b0};
      hi_r   <= '0;
      lo_r   <= '0;
      size_r <= '0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      base_r <= base_nxt;
      ext_r  <= ext_nxt;
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      size_r <= size_nxt;
    end
  end

endmodule

@@ design/fdn_out_reg.sv @@
module fdn_out_reg
  import fdn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r;
  result_t data_r;

  assign free       = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import fdn_pkg::*;

  class name_match_scoreboard;
    logic [63:0] base_name;
    logic [23:0] ext_name;
    logic [4:0]  offset;
    logic [1:0]  base_cmp;  // {equal, done}
    logic [1:0]  ext_cmp;
    logic [15:0] cluster_hi;
    logic [15:0] cluster_lo;
    logic [31:0] size_bytes;
    result_t     entry_results[$];
    int          errors;

    function new();
      base_name = TARGET_BASE_RESET;
      ext_name  = TARGET_EXT_RESET;
      errors    = 0;
      restart_entry();
    endfunction

    function void restart_entry();
      offset     = '0;
      base_cmp   = 2'b10;
      ext_cmp    = 2'b10;
      cluster_hi = '0;
      cluster_lo = '0;
      size_bytes = '0;
    endfunction

    function void set_target(cfg_index_t idx, logic [63:0] value);
      if (idx == CFG_TARGET_BASE) base_name = value;
      else ext_name = value[23:0];
    endfunction

    function logic [1:0] cut_compare(logic [7:0] got, logic [7:0] want, logic [1:0] st);
      logic [1:0] nxt;
      nxt = st;
      if (!st[0]) begin
        if (got == SPACE_BYTE || want == SPACE_BYTE) begin
          nxt[0] = 1'b1;
          if (got != want) nxt[1] = 1'b0;
        end else if (got != want) begin
          nxt[1] = 1'b0;
        end
      end
      return nxt;
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      if (offset <= BASE_LAST_OFS) begin
        base_cmp = cut_compare(b, base_name[8*offset +: 8], base_cmp);
      end else if (offset <= EXT_LAST_OFS) begin
        ext_cmp = cut_compare(b, ext_name[8*(offset - EXT_FIRST_OFS) +: 8], ext_cmp);
      end else if (offset == CLUSTER_HIGH_OFS) begin
        cluster_hi[7:0] = b;
      end else if (offset == CLUSTER_HIGH_OFS + 5'd1) begin
        cluster_hi[15:8] = b;
      end else if (offset == CLUSTER_LOW_OFS) begin
        cluster_lo[7:0] = b;
      end else if (offset == CLUSTER_LOW_OFS + 5'd1) begin
        cluster_lo[15:8] = b;
      end else if (offset >= SIZE_OFS) begin
        size_bytes[8*(offset - SIZE_OFS) +: 8] = b;
      end
      if (offset == ENTRY_LAST_OFS) begin
        r.found         = base_cmp[1] & ext_cmp[1];
        r.start_cluster = {cluster_hi, cluster_lo};
        r.file_size     = size_bytes;
        entry_results.push_back(r);
        restart_entry();
      end else begin
        offset = offset + 5'd1;
      end
    endfunction

    function void check(logic [71:0] w);
      result_t e;
      if (entry_results.size() == 0) begin
        $error("result word %h with no entry outstanding", w);
        errors++;
        return;
      end
      e = entry_results.pop_front();
      if (w[0] !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, w[0]);
        errors++;
      end
      if (w[32:1] !== e.start_cluster) begin
        $error("start_cluster: expected %h, got %h", e.start_cluster, w[32:1]);
        errors++;
      end
      if (w[64:33] !== e.file_size) begin
        $error("file_size: expected %h, got %h", e.file_size, w[64:33]);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index  = CFG_TARGET_BASE;
  logic [63:0] cfg_data   = '0;

  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;
  int entry_pos     = 0;

  name_match_scoreboard sb;

  fat_dir_entry_name_match_core DUT (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
  end

  initial begin : receiver
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] non_space();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == SPACE_BYTE);
    return b;
  endfunction

  function automatic logic [63:0] pad_name(string s);
    logic [63:0] r;
    int          k;
    r = {8{SPACE_BYTE}};
    for (k = 0; k < s.len() && k < 8; k++) r[8*k +: 8] = s[k];
    return r;
  endfunction

  function automatic logic [63:0] random_name(int n);
    logic [63:0] r;
    int          len, k;
    r   = {$urandom, $urandom};
    len = $urandom_range(0, n);
    for (k = 0; k < len; k++) r[8*k +: 8] = non_space();
    if (len < n) begin
      r[8*len +: 8] = SPACE_BYTE;
      if ($urandom_range(0, 1) == 1) for (k = len + 1; k < n; k++) r[8*k +: 8] = SPACE_BYTE;
    end
    return r;
  endfunction

  // mostly a copy of the target's cut part, else one byte off, cut short, run long or noise
  function automatic logic [63:0] shape_name(logic [63:0] t, int n);
    logic [63:0] r;
    int          cut, k, mode;
    cut = n;
    for (k = n - 1; k >= 0; k--) if (t[8*k +: 8] == SPACE_BYTE) cut = k;
    r    = {$urandom, $urandom};
    mode = $urandom_range(0, 11);
    if (mode == 11) return r;
    for (k = 0; k < cut; k++) r[8*k +: 8] = t[8*k +: 8];
    if (cut < n) r[8*cut +: 8] = SPACE_BYTE;
    if (mode == 8 && cut > 0) begin
      k = $urandom_range(0, cut - 1);
      r[8*k +: 8] ^= 8'($urandom_range(1, 255));
    end else if (mode == 9 && cut > 0) begin
      k = $urandom_range(0, cut - 1);
      r[8*k +: 8] = SPACE_BYTE;
    end else if (mode == 10 && cut < n) begin
      r[8*cut +: 8] = non_space();
    end
    return r;
  endfunction

  function automatic logic [255:0] make_entry(logic [63:0] base, logic [23:0] ext);
    logic [255:0] e;
    logic [63:0]  x;
    int           k;
    for (k = 0; k < 8; k++) e[32*k +: 32] = $urandom;
    e[63:0]  = shape_name(base, 8);
    x        = shape_name({40'd0, ext}, 3);
    e[87:64] = x[23:0];
    case ($urandom_range(0, 7))
      0: e[255:160] = '1;
      1: e[255:160] = '0;
      default: ;
    endcase
    case ($urandom_range(0, 15))
      0: e[7:0] = 8'hE5;
      1: e[7:0] = 8'h00;
      default: ;
    endcase
    return e;
  endfunction

  function automatic logic [255:0] named_entry(string b, string x, logic [7:0] fill);
    logic [255:0] e;
    logic [63:0]  xn;
    e        = {32{fill}};
    e[63:0]  = pad_name(b);
    xn       = pad_name(x);
    e[87:64] = xn[23:0];
    return e;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    entry_pos = (entry_pos + 1) % 32;
  endtask

  task automatic send_range(input logic [255:0] e, input int first, input int stop);
    int k;
    for (k = first; k < stop; k++) send_byte(e[8*k +: 8]);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.entry_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_target(input cfg_index_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_target(idx, value);
  endtask

  // which: 0 both, 1 base only, 2 extension only
  task automatic load_targets(input logic [63:0] base, input logic [63:0] ext, input int which);
    if (which != 2) write_target(CFG_TARGET_BASE, base);
    if (which != 1) write_target(CFG_TARGET_EXT, ext);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [255:0] e;
    logic [63:0]  b, x;
    int           p, k, which;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    e = {32{SPACE_BYTE}};
    e[255:160] = '1;
    send_range(e, 0, 32);
    send_range({32{8'h00}}, 0, 32);
    settle();

    load_targets(pad_name("README"), pad_name("TXT"), 0);
    send_range(named_entry("README", "TXT", 8'h5A), 0, 32);
    send_range(named_entry("README Q", "TXT", 8'hA5), 0, 32);
    send_range(named_entry("READMEX", "TXT", 8'h01), 0, 32);
    send_range(named_entry("READ", "TXT", 8'h80), 0, 32);
    send_range(named_entry("README", "TX", 8'h7F), 0, 32);
    settle();

    load_targets(pad_name("ABCDEFGH"), pad_name("XYZ"), 0);
    send_range(named_entry("ABCDEFGH", "XYZ", 8'hC3), 0, 32);
    send_range(named_entry("ABCDEFGX", "XYZ", 8'h3C), 0, 32);
    send_range(named_entry("ABCDEFG", "XYZ", 8'h00), 0, 32);
    settle();

    load_targets('0, '0, 0);
    send_range({32{8'h00}}, 0, 32);
    e = '0;
    e[7:0] = 8'hE5;
    send_range(e, 0, 32);
    settle();

    load_targets('1, '1, 0);
    send_range({32{8'hFF}}, 0, 32);

    for (p = 0; p < 14; p++) begin
      settle();
      quiet = (p >= 11);
      which = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      x = {$urandom, $urandom};
      if (p == 0) begin
        x[23:0] = TARGET_EXT_RESET;
        load_targets(TARGET_BASE_RESET, x, 0);
      end else if (p == 1) begin
        load_targets('0, '0, 0);
      end else if (p == 2) begin
        load_targets('1, '1, 0);
      end else begin
        b = random_name(8);
        x[23:0] = 24'(random_name(3));
        load_targets(b, x, which);
      end
      if (p == 2) long_hold_req = 1'b1;
      if (entry_pos != 0) send_range(make_entry(sb.base_name, sb.ext_name), entry_pos, 32);
      for (k = 0; k < 3; k++) send_range(make_entry(sb.base_name, sb.ext_name), 0, 32);
      if ($urandom_range(0, 2) == 0)
        send_range(make_entry(sb.base_name, sb.ext_name), 0, $urandom_range(1, 31));
    end

    if (entry_pos != 0) send_range(make_entry(sb.base_name, sb.ext_name), entry_pos, 32);
    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
